// File: rtl/core/plob_pkg.sv
// ============================================================================
// plob_pkg
// Shared types and constants for the price level order book core.
// ============================================================================
package plob_pkg;

    localparam int PRICE_LEVELS_DEF = 256;
    localparam int ORDER_SLOTS_DEF  = 1024;
    localparam int TRADER_COUNT     = 64;

    localparam int REQ_W    = 2;
    localparam int PRICE_W  = 8;
    localparam int QTY_W    = 32;
    localparam int TRADER_W = 6;
    localparam int HANDLE_W = 10;
    localparam int STATUS_W = 2;
    localparam int MID_W    = 9;
    localparam int WORD_W   = 32;
    localparam int GROUP_W  = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_CHANGE = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_TOP    = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_ORDER   = 2'd1,
        STAT_POOL_FULL  = 2'd2,
        STAT_BAD_HANDLE = 2'd3
    } stat_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_ADD_LINK, S_MOD_RD, S_MOD_WR,
        S_TOP_PICK, S_TOP_LVL, S_TOP_SLOT, S_TOP_FREE, S_TOP_W1, S_TOP_W2,
        S_WAIT1, S_WAIT2, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_CLEAR, CMD_CAPTURE, CMD_ADD_RD, CMD_ADD_WR, CMD_ADD_LINK,
        CMD_MOD_RD, CMD_MOD_WR, CMD_TOP_PICK, CMD_TOP_LVL, CMD_TOP_SLOT,
        CMD_TOP_FREE, CMD_LOAD_OUT
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic pool_full;
        logic needs_link;
        logic side_empty;
        logic level_empty;
        logic head_removed;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic                side;
        logic [PRICE_W-1:0]  price;
        logic                ioc;
        logic [TRADER_W-1:0] owner;
    } slot_info_t;

endpackage

// File: rtl/core/plob_best.sv
// ============================================================================
// plob_best
// Registered two-level search for the best bid and best ask level.
// ============================================================================
module plob_best #(
    parameter  int PRICE_LEVELS = plob_pkg::PRICE_LEVELS_DEF,
    localparam int PW           = $clog2(PRICE_LEVELS)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [1:0][PRICE_LEVELS-1:0]     present,
    output logic [1:0]                       best_valid,
    output logic [1:0][PW-1:0]               best_idx
);

    localparam int GW  = plob_pkg::GROUP_W;
    localparam int NG  = (PRICE_LEVELS + GW - 1) / GW;
    localparam int GB  = $clog2(GW);
    localparam int PADW = NG * GW;

    logic [1:0][PADW-1:0]          padded;
    logic [1:0][NG-1:0]            g_any_reg, g_any_next;
    logic [1:0][NG-1:0][GB-1:0]    g_idx_reg, g_idx_next;
    logic [1:0]                    best_valid_reg, best_valid_next;
    logic [1:0][PW-1:0]            best_idx_reg, best_idx_next;

    assign padded[0] = PADW'(present[0]);
    assign padded[1] = PADW'(present[1]);

    // group scan: bid keeps highest, ask keeps lowest
    always_comb begin
        g_any_next = '0;
        g_idx_next = '0;
        for (int g = 0; g < NG; g++) begin
            for (int i = 0; i < GW; i++) begin
                if (padded[0][g*GW+i]) begin
                    g_any_next[0][g] = 1'b1;
                    g_idx_next[0][g] = GB'(i);
                end
            end
            for (int i = GW - 1; i >= 0; i--) begin
                if (padded[1][g*GW+i]) begin
                    g_any_next[1][g] = 1'b1;
                    g_idx_next[1][g] = GB'(i);
                end
            end
        end
    end

    always_comb begin
        best_valid_next = '0;
        best_idx_next   = '0;
        for (int g = 0; g < NG; g++) begin
            if (g_any_reg[0][g]) begin
                best_valid_next[0] = 1'b1;
                best_idx_next[0]   = PW'(g * GW + int'(g_idx_reg[0][g]));
            end
        end
        for (int g = NG - 1; g >= 0; g--) begin
            if (g_any_reg[1][g]) begin
                best_valid_next[1] = 1'b1;
                best_idx_next[1]   = PW'(g * GW + int'(g_idx_reg[1][g]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_any_reg      <= '0;
            best_valid_reg <= '0;
        end else begin
            g_any_reg      <= g_any_next;
            best_valid_reg <= best_valid_next;
        end
        g_idx_reg    <= g_idx_next;
        best_idx_reg <= best_idx_next;
    end

    assign best_valid = best_valid_reg;
    assign best_idx   = best_idx_reg;

endmodule

// File: rtl/core/plob_datapath.sv
// ============================================================================
// plob_datapath
// Order pool, level queues, free slot bitmap and result registers.
// ============================================================================
module plob_datapath #(
    parameter int PRICE_LEVELS = plob_pkg::PRICE_LEVELS_DEF,
    parameter int ORDER_SLOTS  = plob_pkg::ORDER_SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  plob_pkg::cmd_t                      cmd,
    output plob_pkg::dp_status_t                status,
    input  logic [plob_pkg::REQ_W-1:0]          s_req_type,
    input  logic                                s_side,
    input  logic [plob_pkg::PRICE_W-1:0]        s_price_level,
    input  logic signed [plob_pkg::QTY_W-1:0]   s_quantity,
    input  logic                                s_ioc_flag,
    input  logic [plob_pkg::TRADER_W-1:0]       s_trader_id,
    input  logic [plob_pkg::HANDLE_W-1:0]       s_order_handle,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [plob_pkg::STATUS_W-1:0]       m_status,
    output logic [plob_pkg::HANDLE_W-1:0]       m_result_handle,
    output logic                                m_book_two_sided,
    output logic [plob_pkg::MID_W-1:0]          m_midprice_half_ticks,
    output logic                                m_event_valid,
    output logic                                m_event_side,
    output logic [plob_pkg::PRICE_W-1:0]        m_event_price,
    output logic signed [plob_pkg::QTY_W-1:0]   m_event_quantity,
    output logic                                m_event_ioc,
    output logic [plob_pkg::TRADER_W-1:0]       m_event_trader
);

    localparam int SW   = $clog2(ORDER_SLOTS);
    localparam int PW   = $clog2(PRICE_LEVELS);
    localparam int LW   = PW + 1;
    localparam int LENW = $clog2(ORDER_SLOTS + 1);
    localparam int WDW  = plob_pkg::WORD_W;
    localparam int BW   = $clog2(WDW);
    localparam int NW   = (ORDER_SLOTS + WDW - 1) / WDW;
    localparam int WW   = (NW > 1) ? $clog2(NW) : 1;
    localparam int HW   = plob_pkg::HANDLE_W;
    localparam int QW   = plob_pkg::QTY_W;

    typedef struct packed {
        logic [SW-1:0]   head;
        logic [SW-1:0]   tail;
        logic [LENW-1:0] len;
    } level_t;

    function automatic logic [WDW-1:0] init_word(input logic [WW-1:0] w);
        logic [WDW-1:0] r;
        for (int i = 0; i < WDW; i++) begin
            r[i] = ((int'(w) * WDW + i) < ORDER_SLOTS);
        end
        return r;
    endfunction

    // request registers
    plob_pkg::req_t                 req_reg;
    logic                           side_reg;
    logic [plob_pkg::PRICE_W-1:0]   price_reg;
    logic signed [QW-1:0]           qty_reg;
    logic                           ioc_reg;
    logic [plob_pkg::TRADER_W-1:0]  trader_reg;
    logic [HW-1:0]                  handle_reg;
    logic [plob_pkg::PRICE_W-1:0]   price_sat;
    logic [plob_pkg::TRADER_W-1:0]  trader_sat;

    // result registers
    plob_pkg::stat_t                res_status_reg, res_status_next;
    logic [HW-1:0]                  res_handle_reg, res_handle_next;
    logic                           ev_valid_reg, ev_valid_next;
    logic                           ev_side_reg, ev_side_next;
    logic [plob_pkg::PRICE_W-1:0]   ev_price_reg, ev_price_next;
    logic signed [QW-1:0]           ev_qty_reg, ev_qty_next;
    logic                           ev_ioc_reg, ev_ioc_next;
    logic [plob_pkg::TRADER_W-1:0]  ev_trader_reg, ev_trader_next;

    // control state
    logic [NW-1:0]                  summary_reg, summary_next;
    logic [WW-1:0]                  clr_cnt_reg, clr_cnt_next;
    logic [1:0][PRICE_LEVELS-1:0]   present_reg, present_next;
    logic                           m_valid_reg;

    // working registers
    logic [WW-1:0]                  alloc_w_reg, alloc_w_next;
    logic [SW-1:0]                  new_slot_reg, new_slot_next;
    logic [SW-1:0]                  link_tail_reg, link_tail_next;
    logic [LW-1:0]                  top_lv_reg, top_lv_next;
    logic [SW-1:0]                  free_slot_reg, free_slot_next;
    logic                           oor_reg, oor_next;

    // memories
    logic [WDW-1:0]                 fword_mem [NW];
    plob_pkg::slot_info_t           info_mem [ORDER_SLOTS];
    logic signed [QW-1:0]           qty_mem [ORDER_SLOTS];
    logic                           rm_mem [ORDER_SLOTS];
    logic [SW-1:0]                  next_mem [ORDER_SLOTS];
    level_t                         level_mem [2**LW];

    logic                           fw_re, fw_we;
    logic [WW-1:0]                  fw_raddr, fw_waddr;
    logic [WDW-1:0]                 fw_wdata, fw_rd;
    logic                           slot_re, info_we, qty_we, rm_we, next_we;
    logic [SW-1:0]                  slot_raddr, slot_waddr, next_waddr, next_wdata;
    plob_pkg::slot_info_t           info_wdata, info_rd;
    logic signed [QW-1:0]           qty_wdata, qty_rd;
    logic                           rm_wdata, rm_rd;
    logic [SW-1:0]                  next_rd;
    logic                           lvl_re, lvl_we;
    logic [LW-1:0]                  lvl_raddr, lvl_waddr;
    level_t                         lvl_wdata, lvl_rd;

    // best levels
    logic [1:0]                     best_valid;
    logic [1:0][PW-1:0]             best_idx;

    // helpers
    logic [WW-1:0]                  alloc_w;
    logic [BW-1:0]                  alloc_bit;
    logic [SW-1:0]                  add_slot;
    logic [WDW-1:0]                 add_word_new;
    logic [LW-1:0]                  req_lv;
    logic                           lvl_new;
    logic signed [QW:0]             mod_sum;
    logic signed [QW-1:0]           mod_sat;
    logic signed [QW-1:0]           neg_cur;
    logic                           mod_bad;
    logic [WW-1:0]                  free_w;
    logic [BW-1:0]                  free_b;

    plob_best #(
        .PRICE_LEVELS (PRICE_LEVELS)
    ) u_best (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .present    (present_reg),
        .best_valid (best_valid),
        .best_idx   (best_idx)
    );

    assign price_sat  = (32'(s_price_level) >= PRICE_LEVELS) ?
                        plob_pkg::PRICE_W'(PRICE_LEVELS - 1) : s_price_level;
    assign trader_sat = (32'(s_trader_id) >= plob_pkg::TRADER_COUNT) ?
                        plob_pkg::TRADER_W'(plob_pkg::TRADER_COUNT - 1) : s_trader_id;

    always_comb begin
        alloc_w = '0;
        for (int i = NW - 1; i >= 0; i--) begin
            if (summary_reg[i]) begin
                alloc_w = WW'(i);
            end
        end
    end

    always_comb begin
        alloc_bit = '0;
        for (int i = WDW - 1; i >= 0; i--) begin
            if (fw_rd[i]) begin
                alloc_bit = BW'(i);
            end
        end
    end

    assign add_slot     = SW'({alloc_w_reg, alloc_bit});
    assign add_word_new = fw_rd & ~(WDW'(1) << alloc_bit);
    assign req_lv       = {side_reg, PW'(price_reg)};
    assign lvl_new      = !present_reg[side_reg][PW'(price_reg)] || (lvl_rd.len == '0);
    assign mod_sum      = (QW+1)'(qty_rd) + (QW+1)'(qty_reg);
    assign mod_sat      = (mod_sum[QW] != mod_sum[QW-1]) ?
                          (mod_sum[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}}) :
                          mod_sum[QW-1:0];
    assign neg_cur      = -qty_rd;
    assign mod_bad      = oor_reg || fw_rd[handle_reg[BW-1:0]] || rm_rd;
    assign free_w       = WW'(free_slot_reg >> BW);
    assign free_b       = BW'(free_slot_reg);

    always_comb begin
        fw_re = 1'b0; fw_we = 1'b0; fw_raddr = '0; fw_waddr = '0; fw_wdata = '0;
        slot_re = 1'b0; info_we = 1'b0; qty_we = 1'b0; rm_we = 1'b0; next_we = 1'b0;
        slot_raddr = '0; slot_waddr = '0; next_waddr = '0; next_wdata = '0;
        info_wdata = '0; qty_wdata = '0; rm_wdata = 1'b0;
        lvl_re = 1'b0; lvl_we = 1'b0; lvl_raddr = '0; lvl_waddr = '0; lvl_wdata = '0;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        ev_valid_next   = ev_valid_reg;
        ev_side_next    = ev_side_reg;
        ev_price_next   = ev_price_reg;
        ev_qty_next     = ev_qty_reg;
        ev_ioc_next     = ev_ioc_reg;
        ev_trader_next  = ev_trader_reg;
        summary_next    = summary_reg;
        clr_cnt_next    = clr_cnt_reg;
        present_next    = present_reg;
        alloc_w_next    = alloc_w_reg;
        new_slot_next   = new_slot_reg;
        link_tail_next  = link_tail_reg;
        top_lv_next     = top_lv_reg;
        free_slot_next  = free_slot_reg;
        oor_next        = oor_reg;
        unique case (cmd)
            plob_pkg::CMD_NONE: begin
            end
            plob_pkg::CMD_CLEAR: begin
                fw_we        = 1'b1;
                fw_waddr     = clr_cnt_reg;
                fw_wdata     = init_word(clr_cnt_reg);
                clr_cnt_next = clr_cnt_reg + WW'(1);
            end
            plob_pkg::CMD_CAPTURE: begin
                res_status_next = plob_pkg::STAT_OK;
                res_handle_next = '0;
                ev_valid_next   = 1'b0;
                ev_side_next    = 1'b0;
                ev_price_next   = '0;
                ev_qty_next     = '0;
                ev_ioc_next     = 1'b0;
                ev_trader_next  = '0;
            end
            plob_pkg::CMD_ADD_RD: begin
                if (summary_reg == '0) begin
                    res_status_next = plob_pkg::STAT_POOL_FULL;
                end else begin
                    fw_re        = 1'b1;
                    fw_raddr     = alloc_w;
                    alloc_w_next = alloc_w;
                    lvl_re       = 1'b1;
                    lvl_raddr    = req_lv;
                end
            end
            plob_pkg::CMD_ADD_WR: begin
                fw_we                     = 1'b1;
                fw_waddr                  = alloc_w_reg;
                fw_wdata                  = add_word_new;
                summary_next[alloc_w_reg] = |add_word_new;
                slot_waddr                = add_slot;
                info_we                   = 1'b1;
                info_wdata                = '{side: side_reg, price: price_reg,
                                              ioc: ioc_reg, owner: trader_reg};
                qty_we                    = 1'b1;
                qty_wdata                 = qty_reg;
                rm_we                     = 1'b1;
                rm_wdata                  = 1'b0;
                next_we                   = 1'b1;
                next_waddr                = add_slot;
                next_wdata                = '0;
                lvl_we                    = 1'b1;
                lvl_waddr                 = req_lv;
                lvl_wdata.head            = lvl_new ? add_slot : lvl_rd.head;
                lvl_wdata.tail            = add_slot;
                lvl_wdata.len             = lvl_new ? LENW'(1) : lvl_rd.len + LENW'(1);
                present_next[side_reg][PW'(price_reg)] = 1'b1;
                link_tail_next            = lvl_rd.tail;
                new_slot_next             = add_slot;
                res_handle_next           = HW'(add_slot);
                ev_valid_next             = 1'b1;
                ev_side_next              = side_reg;
                ev_price_next             = price_reg;
                ev_qty_next               = qty_reg;
                ev_ioc_next               = ioc_reg;
                ev_trader_next            = trader_reg;
            end
            plob_pkg::CMD_ADD_LINK: begin
                next_we    = 1'b1;
                next_waddr = link_tail_reg;
                next_wdata = new_slot_reg;
            end
            plob_pkg::CMD_MOD_RD: begin
                slot_re    = 1'b1;
                slot_raddr = SW'(handle_reg);
                fw_re      = 1'b1;
                fw_raddr   = WW'(handle_reg >> BW);
                oor_next   = (32'(handle_reg) >= ORDER_SLOTS);
            end
            plob_pkg::CMD_MOD_WR: begin
                if (mod_bad) begin
                    res_status_next = plob_pkg::STAT_BAD_HANDLE;
                end else begin
                    slot_waddr     = SW'(handle_reg);
                    ev_valid_next  = 1'b1;
                    ev_side_next   = info_rd.side;
                    ev_price_next  = info_rd.price;
                    ev_ioc_next    = info_rd.ioc;
                    ev_trader_next = info_rd.owner;
                    if (req_reg == plob_pkg::REQ_REMOVE || mod_sum == '0) begin
                        ev_qty_next = neg_cur;
                        rm_we       = 1'b1;
                        rm_wdata    = 1'b1;
                    end else begin
                        ev_qty_next = qty_reg;
                        qty_we      = 1'b1;
                        qty_wdata   = mod_sat;
                    end
                end
            end
            plob_pkg::CMD_TOP_PICK: begin
                if (!best_valid[side_reg]) begin
                    res_status_next = plob_pkg::STAT_NO_ORDER;
                end else begin
                    lvl_re      = 1'b1;
                    lvl_raddr   = {side_reg, best_idx[side_reg]};
                    top_lv_next = {side_reg, best_idx[side_reg]};
                end
            end
            plob_pkg::CMD_TOP_LVL: begin
                if (lvl_rd.len == '0) begin
                    present_next[top_lv_reg[LW-1]][top_lv_reg[PW-1:0]] = 1'b0;
                end else begin
                    slot_re    = 1'b1;
                    slot_raddr = lvl_rd.head;
                end
            end
            plob_pkg::CMD_TOP_SLOT: begin
                if (rm_rd) begin
                    lvl_we         = 1'b1;
                    lvl_waddr      = top_lv_reg;
                    lvl_wdata.head = next_rd;
                    lvl_wdata.tail = lvl_rd.tail;
                    lvl_wdata.len  = lvl_rd.len - LENW'(1);
                    fw_re          = 1'b1;
                    fw_raddr       = WW'(lvl_rd.head >> BW);
                    free_slot_next = lvl_rd.head;
                end else begin
                    res_handle_next = HW'(lvl_rd.head);
                end
            end
            plob_pkg::CMD_TOP_FREE: begin
                fw_we                = 1'b1;
                fw_waddr             = free_w;
                fw_wdata             = fw_rd | (WDW'(1) << free_b);
                summary_next[free_w] = 1'b1;
            end
            plob_pkg::CMD_LOAD_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (fw_we) begin
            fword_mem[fw_waddr] <= fw_wdata;
        end
        if (fw_re) begin
            fw_rd <= fword_mem[fw_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (info_we) begin
            info_mem[slot_waddr] <= info_wdata;
        end
        if (qty_we) begin
            qty_mem[slot_waddr] <= qty_wdata;
        end
        if (rm_we) begin
            rm_mem[slot_waddr] <= rm_wdata;
        end
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (slot_re) begin
            info_rd <= info_mem[slot_raddr];
            qty_rd  <= qty_mem[slot_raddr];
            rm_rd   <= rm_mem[slot_raddr];
            next_rd <= next_mem[slot_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            level_mem[lvl_waddr] <= lvl_wdata;
        end
        if (lvl_re) begin
            lvl_rd <= level_mem[lvl_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            summary_reg <= '1;
            clr_cnt_reg <= '0;
            present_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            summary_reg <= summary_next;
            clr_cnt_reg <= clr_cnt_next;
            present_reg <= present_next;
            if (cmd == plob_pkg::CMD_LOAD_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd == plob_pkg::CMD_CAPTURE) begin
            req_reg    <= plob_pkg::req_t'(s_req_type);
            side_reg   <= s_side;
            price_reg  <= price_sat;
            qty_reg    <= s_quantity;
            ioc_reg    <= s_ioc_flag;
            trader_reg <= trader_sat;
            handle_reg <= s_order_handle;
        end
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        ev_valid_reg   <= ev_valid_next;
        ev_side_reg    <= ev_side_next;
        ev_price_reg   <= ev_price_next;
        ev_qty_reg     <= ev_qty_next;
        ev_ioc_reg     <= ev_ioc_next;
        ev_trader_reg  <= ev_trader_next;
        alloc_w_reg    <= alloc_w_next;
        new_slot_reg   <= new_slot_next;
        link_tail_reg  <= link_tail_next;
        top_lv_reg     <= top_lv_next;
        free_slot_reg  <= free_slot_next;
        oor_reg        <= oor_next;
        if (cmd == plob_pkg::CMD_LOAD_OUT) begin
            m_status              <= res_status_reg;
            m_result_handle       <= res_handle_reg;
            m_book_two_sided      <= best_valid[0] && best_valid[1];
            m_midprice_half_ticks <= (best_valid[0] && best_valid[1]) ?
                plob_pkg::MID_W'(32'(best_idx[0]) + 32'(best_idx[1])) : '0;
            m_event_valid         <= ev_valid_reg;
            m_event_side          <= ev_side_reg;
            m_event_price         <= ev_price_reg;
            m_event_quantity      <= ev_qty_reg;
            m_event_ioc           <= ev_ioc_reg;
            m_event_trader        <= ev_trader_reg;
        end
    end

    assign m_valid = m_valid_reg;

    assign status.clear_done   = (clr_cnt_reg == WW'(NW - 1));
    assign status.pool_full    = (summary_reg == '0);
    assign status.needs_link   = !lvl_new;
    assign status.side_empty   = !best_valid[side_reg];
    assign status.level_empty  = (lvl_rd.len == '0);
    assign status.head_removed = rm_rd;
    assign status.out_free     = !m_valid_reg || m_ready;

endmodule

// File: rtl/core/plob_ctrl.sv
// ============================================================================
// plob_ctrl
// Request sequencer for the order book datapath.
// ============================================================================
module plob_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [plob_pkg::REQ_W-1:0]  s_req_type,
    input  plob_pkg::dp_status_t        status,
    output plob_pkg::cmd_t              cmd
);

    plob_pkg::state_t state_reg, state_next;
    plob_pkg::req_t   req;

    assign req = plob_pkg::req_t'(s_req_type);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            plob_pkg::S_CLEAR: begin
                if (status.clear_done) begin
                    state_next = plob_pkg::S_IDLE;
                end
            end
            plob_pkg::S_IDLE: begin
                if (s_valid) begin
                    unique case (req) inside
                        plob_pkg::REQ_ADD:                      state_next = plob_pkg::S_ADD_RD;
                        plob_pkg::REQ_CHANGE, plob_pkg::REQ_REMOVE: state_next = plob_pkg::S_MOD_RD;
                        plob_pkg::REQ_TOP:                      state_next = plob_pkg::S_TOP_PICK;
                        default:                                state_next = plob_pkg::S_IDLE;
                    endcase
                end
            end
            plob_pkg::S_ADD_RD: begin
                state_next = status.pool_full ? plob_pkg::S_DONE : plob_pkg::S_ADD_WR;
            end
            plob_pkg::S_ADD_WR: begin
                state_next = status.needs_link ? plob_pkg::S_ADD_LINK : plob_pkg::S_WAIT1;
            end
            plob_pkg::S_ADD_LINK: state_next = plob_pkg::S_WAIT1;
            plob_pkg::S_MOD_RD:   state_next = plob_pkg::S_MOD_WR;
            plob_pkg::S_MOD_WR:   state_next = plob_pkg::S_DONE;
            plob_pkg::S_TOP_PICK: begin
                state_next = status.side_empty ? plob_pkg::S_DONE : plob_pkg::S_TOP_LVL;
            end
            plob_pkg::S_TOP_LVL: begin
                state_next = status.level_empty ? plob_pkg::S_TOP_W1 : plob_pkg::S_TOP_SLOT;
            end
            plob_pkg::S_TOP_SLOT: begin
                state_next = status.head_removed ? plob_pkg::S_TOP_FREE : plob_pkg::S_DONE;
            end
            plob_pkg::S_TOP_FREE: state_next = plob_pkg::S_TOP_PICK;
            plob_pkg::S_TOP_W1:   state_next = plob_pkg::S_TOP_W2;
            plob_pkg::S_TOP_W2:   state_next = plob_pkg::S_TOP_PICK;
            plob_pkg::S_WAIT1:    state_next = plob_pkg::S_WAIT2;
            plob_pkg::S_WAIT2:    state_next = plob_pkg::S_DONE;
            plob_pkg::S_DONE: begin
                if (status.out_free) begin
                    state_next = plob_pkg::S_IDLE;
                end
            end
            default: state_next = plob_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = plob_pkg::CMD_NONE;
        unique case (state_reg)
            plob_pkg::S_CLEAR:    cmd = plob_pkg::CMD_CLEAR;
            plob_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd = plob_pkg::CMD_CAPTURE;
                end
            end
            plob_pkg::S_ADD_RD:   cmd = plob_pkg::CMD_ADD_RD;
            plob_pkg::S_ADD_WR:   cmd = plob_pkg::CMD_ADD_WR;
            plob_pkg::S_ADD_LINK: cmd = plob_pkg::CMD_ADD_LINK;
            plob_pkg::S_MOD_RD:   cmd = plob_pkg::CMD_MOD_RD;
            plob_pkg::S_MOD_WR:   cmd = plob_pkg::CMD_MOD_WR;
            plob_pkg::S_TOP_PICK: cmd = plob_pkg::CMD_TOP_PICK;
            plob_pkg::S_TOP_LVL:  cmd = plob_pkg::CMD_TOP_LVL;
            plob_pkg::S_TOP_SLOT: cmd = plob_pkg::CMD_TOP_SLOT;
            plob_pkg::S_TOP_FREE: cmd = plob_pkg::CMD_TOP_FREE;
            plob_pkg::S_TOP_W1, plob_pkg::S_TOP_W2, plob_pkg::S_WAIT1, plob_pkg::S_WAIT2: begin
                cmd = plob_pkg::CMD_NONE;
            end
            plob_pkg::S_DONE: begin
                if (status.out_free) begin
                    cmd = plob_pkg::CMD_LOAD_OUT;
                end
            end
            default: cmd = plob_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= plob_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_capture_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == plob_pkg::S_IDLE && s_valid) |=> (state_reg != plob_pkg::S_IDLE))
        else $error("transaction accepted but sequencer stayed idle");
    a_link_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == plob_pkg::S_ADD_LINK) |-> ($past(state_reg) == plob_pkg::S_ADD_WR))
        else $error("tail link without slot write");
    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == plob_pkg::S_DONE && status.out_free) |=> (state_reg == plob_pkg::S_IDLE))
        else $error("result loaded but sequencer not idle");
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != plob_pkg::S_CLEAR) |=> (state_reg != plob_pkg::S_CLEAR))
        else $error("clearing pass re-entered");
`endif

endmodule

// File: rtl/core/price_level_order_book_core.sv
// ============================================================================
// price_level_order_book_core
// Two-sided limit order book with price-time priority and midprice report.
// ============================================================================
// After reset every word of the free-slot bitmap is swept before the first
// transaction is accepted. One request is handled at a time; each returns
// exactly one result. Change and remove read the slot, then write it; add
// does one memory read, one write, an optional tail link, then waits in
// WAIT1 and WAIT2 for the registered best-level search to settle; an add to
// a full pool ends after the read. A top query picks the best level (and
// ends there on an empty side), reads it, then its head slot, popping every
// removed head and dropping every emptied level, bounded by the level-queue
// walk. The output register lets the next request start while a result
// waits; a second result then holds the sequencer until the first is taken.
module price_level_order_book_core #(
    parameter int PRICE_LEVELS = plob_pkg::PRICE_LEVELS_DEF,
    parameter int ORDER_SLOTS  = plob_pkg::ORDER_SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [plob_pkg::REQ_W-1:0]          s_req_type,
    input  logic                                s_side,
    input  logic [plob_pkg::PRICE_W-1:0]        s_price_level,
    input  logic signed [plob_pkg::QTY_W-1:0]   s_quantity,
    input  logic                                s_ioc_flag,
    input  logic [plob_pkg::TRADER_W-1:0]       s_trader_id,
    input  logic [plob_pkg::HANDLE_W-1:0]       s_order_handle,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [plob_pkg::STATUS_W-1:0]       m_status,
    output logic [plob_pkg::HANDLE_W-1:0]       m_result_handle,
    output logic                                m_book_two_sided,
    output logic [plob_pkg::MID_W-1:0]          m_midprice_half_ticks,
    output logic                                m_event_valid,
    output logic                                m_event_side,
    output logic [plob_pkg::PRICE_W-1:0]        m_event_price,
    output logic signed [plob_pkg::QTY_W-1:0]   m_event_quantity,
    output logic                                m_event_ioc,
    output logic [plob_pkg::TRADER_W-1:0]       m_event_trader
);

    plob_pkg::cmd_t       cmd;
    plob_pkg::dp_status_t status;

    plob_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .status     (status),
        .cmd        (cmd)
    );

    plob_datapath #(
        .PRICE_LEVELS (PRICE_LEVELS),
        .ORDER_SLOTS  (ORDER_SLOTS)
    ) u_datapath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .s_req_type            (s_req_type),
        .s_side                (s_side),
        .s_price_level         (s_price_level),
        .s_quantity            (s_quantity),
        .s_ioc_flag            (s_ioc_flag),
        .s_trader_id           (s_trader_id),
        .s_order_handle        (s_order_handle),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_status              (m_status),
        .m_result_handle       (m_result_handle),
        .m_book_two_sided      (m_book_two_sided),
        .m_midprice_half_ticks (m_midprice_half_ticks),
        .m_event_valid         (m_event_valid),
        .m_event_side          (m_event_side),
        .m_event_price         (m_event_price),
        .m_event_quantity      (m_event_quantity),
        .m_event_ioc           (m_event_ioc),
        .m_event_trader        (m_event_trader)
    );

endmodule
